FILE: src/gtca_pkg.sv
// Shared types and constants for the grid topology cell address unit.
// Holds the edge mode codes, register indexes and the small control structs
// that move between the pipeline modules. Depends on nothing.
`timescale 1ns / 1ps

package gtca_pkg;

    // Field and port widths fixed by the interface
    localparam int COORD_W    = 16;
    localparam int INDEX_W    = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Largest side the side registers can hold
    localparam int SIDE_REG_MAX = (2 ** CFG_DATA_W) - 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd2;

    // Edge topology; codes 6 and 7 behave as torus
    typedef enum logic [2:0] {
        EM_TORUS    = 3'd0,
        EM_FINITE   = 3'd1,
        EM_CYLINDER = 3'd2,
        EM_KLEIN    = 3'd3,
        EM_CROSS    = 3'd4,
        EM_SPHERE   = 3'd5
    } t_edge_mode;

    // Per-item flags carried alongside the first divider
    typedef struct packed {
        logic ok;
        logic neg_x;
        logic neg_z;
    } t_axis_flags;

    // Low quotient bit of each divider lane
    typedef struct packed {
        logic a;
        logic b;
    } t_lane_odd;

    // Routing decision carried alongside the second divider
    typedef struct packed {
        logic ok;
        logic swap;
    } t_route;

endpackage

FILE: src/gtca_divpipe.sv
// Two-lane pipelined restoring divider: one quotient bit per stage.
// Gives remainder and low quotient bit of each lane, carrying a sideband.
// Depends on gtca_pkg.
`timescale 1ns / 1ps

module gtca_divpipe #(
    parameter int DW   = 15,
    parameter int RW   = 12,
    parameter int SB_W = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_ce,
    input  logic                  i_valid,
    input  logic [DW-1:0]         i_dvd_a,
    input  logic [DW-1:0]         i_dvd_b,
    input  logic [RW:0]           i_den_a,
    input  logic [RW:0]           i_den_b,
    input  logic [SB_W-1:0]       i_sb,
    output logic                  o_valid,
    output logic [RW-1:0]         o_rem_a,
    output logic [RW-1:0]         o_rem_b,
    output gtca_pkg::t_lane_odd   o_odd,
    output logic [SB_W-1:0]       o_sb
);
    import gtca_pkg::*;

    logic            r_vld   [DW];
    logic            n_vld   [DW];
    logic [RW-1:0]   r_rem_a [DW];
    logic [RW-1:0]   n_rem_a [DW];
    logic [RW-1:0]   r_rem_b [DW];
    logic [RW-1:0]   n_rem_b [DW];
    logic [DW-1:0]   r_dvd_a [DW];
    logic [DW-1:0]   n_dvd_a [DW];
    logic [DW-1:0]   r_dvd_b [DW];
    logic [DW-1:0]   n_dvd_b [DW];
    logic            r_q_a   [DW];
    logic            n_q_a   [DW];
    logic            r_q_b   [DW];
    logic            n_q_b   [DW];
    logic [SB_W-1:0] r_sb    [DW];
    logic [SB_W-1:0] n_sb    [DW];

    // One compare-subtract step: {quotient bit, new partial remainder}
    function automatic logic [RW:0] f_step(input logic [RW-1:0] rem, input logic b,
                                           input logic [RW:0] den);
        logic [RW:0] trial;
        trial = {rem, b};
        if (trial >= den) begin
            f_step = {1'b1, RW'(trial - den)};
        end else begin
            f_step = {1'b0, trial[RW-1:0]};
        end
    endfunction

    // Next value of every stage, each from the stage before it
    always_comb begin
        logic [RW:0] v_step_a;
        logic [RW:0] v_step_b;
        v_step_a   = f_step('0, i_dvd_a[DW-1], i_den_a);
        v_step_b   = f_step('0, i_dvd_b[DW-1], i_den_b);
        n_vld[0]   = i_valid;
        n_sb[0]    = i_sb;
        n_rem_a[0] = v_step_a[RW-1:0];
        n_rem_b[0] = v_step_b[RW-1:0];
        n_q_a[0]   = v_step_a[RW];
        n_q_b[0]   = v_step_b[RW];
        n_dvd_a[0] = i_dvd_a << 1;
        n_dvd_b[0] = i_dvd_b << 1;
        for (int k = 1; k < DW; k++) begin
            v_step_a   = f_step(r_rem_a[k-1], r_dvd_a[k-1][DW-1], i_den_a);
            v_step_b   = f_step(r_rem_b[k-1], r_dvd_b[k-1][DW-1], i_den_b);
            n_vld[k]   = r_vld[k-1];
            n_sb[k]    = r_sb[k-1];
            n_rem_a[k] = v_step_a[RW-1:0];
            n_rem_b[k] = v_step_b[RW-1:0];
            n_q_a[k]   = v_step_a[RW];
            n_q_b[k]   = v_step_b[RW];
            n_dvd_a[k] = r_dvd_a[k-1] << 1;
            n_dvd_b[k] = r_dvd_b[k-1] << 1;
        end
    end

    // Advance valid bits with the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '{default: 1'b0};
        end else if (i_ce) begin
            r_vld <= n_vld;
        end
    end

    // Advance payload with the pipeline
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_rem_a <= n_rem_a;
            r_rem_b <= n_rem_b;
            r_dvd_a <= n_dvd_a;
            r_dvd_b <= n_dvd_b;
            r_q_a   <= n_q_a;
            r_q_b   <= n_q_b;
            r_sb    <= n_sb;
        end
    end

    assign o_valid = r_vld[DW-1];
    assign o_rem_a = r_rem_a[DW-1];
    assign o_rem_b = r_rem_b[DW-1];
    assign o_odd.a = r_q_a[DW-1];
    assign o_odd.b = r_q_b[DW-1];
    assign o_sb    = r_sb[DW-1];

    // Remainders always fall below their divisors
    a_rem_a_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((RW+1)'(o_rem_a) < i_den_a))
        else $error("divider lane a remainder not below divisor");

    a_rem_b_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((RW+1)'(o_rem_b) < i_den_b))
        else $error("divider lane b remainder not below divisor");

endmodule

FILE: src/gtca_select.sv
// Topology select stage: forms wrapped, reversed and twist values per axis
// from the divider results and picks the route for the edge mode.
// Depends on gtca_pkg.
`timescale 1ns / 1ps

module gtca_select #(
    parameter int RW = 12,
    parameter int SW = 13
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_ce,
    input  logic                  i_valid,
    input  gtca_pkg::t_edge_mode  i_mode,
    input  logic [SW-1:0]         i_nx,
    input  logic [SW-1:0]         i_nz,
    input  logic [RW-1:0]         i_rem_x,
    input  logic [RW-1:0]         i_rem_z,
    input  gtca_pkg::t_lane_odd   i_odd,
    input  gtca_pkg::t_axis_flags i_flags,
    output logic                  o_valid,
    output logic [RW-1:0]         o_a,
    output logic [RW-1:0]         o_b,
    output gtca_pkg::t_route      o_route
);
    import gtca_pkg::*;

    logic          r_vld;
    logic [RW-1:0] r_a;
    logic [RW-1:0] n_a;
    logic [RW-1:0] r_b;
    logic [RW-1:0] n_b;
    t_route        r_route;
    t_route        n_route;

    // Build per-axis candidates and route by mode
    always_comb begin
        logic [RW-1:0] v_nxm1;
        logic [RW-1:0] v_nzm1;
        logic [RW-1:0] v_wx;
        logic [RW-1:0] v_fx;
        logic [RW-1:0] v_wz;
        logic [RW-1:0] v_fz;
        logic          v_tx;
        logic          v_tz;
        v_nxm1 = RW'(i_nx - SW'(1));
        v_nzm1 = RW'(i_nz - SW'(1));
        // A negative coordinate was divided as its ones' complement
        v_wx   = i_flags.neg_x ? (v_nxm1 - i_rem_x) : i_rem_x;
        v_fx   = i_flags.neg_x ? i_rem_x : (v_nxm1 - i_rem_x);
        v_wz   = i_flags.neg_z ? (v_nzm1 - i_rem_z) : i_rem_z;
        v_fz   = i_flags.neg_z ? i_rem_z : (v_nzm1 - i_rem_z);
        v_tx   = i_odd.a ^ i_flags.neg_x;
        v_tz   = i_odd.b ^ i_flags.neg_z;

        n_a          = v_wx;
        n_b          = v_wz;
        n_route.ok   = i_flags.ok;
        n_route.swap = 1'b0;
        case (i_mode)
            EM_KLEIN: begin
                n_a = v_tz ? v_fx : v_wx;
            end
            EM_CROSS: begin
                n_a = v_tz ? v_fx : v_wx;
                n_b = v_tx ? v_fz : v_wz;
            end
            EM_SPHERE: begin
                case ({v_tz, v_tx})
                    2'b01: begin
                        n_b          = v_fz;
                        n_route.swap = 1'b1;
                    end
                    2'b10: begin
                        n_a          = v_fx;
                        n_route.swap = 1'b1;
                    end
                    2'b11: begin
                        n_a = v_fx;
                        n_b = v_fz;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // Hold the valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ce) begin
            r_vld <= i_valid;
        end
    end

    // Hold the selected candidates
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_a     <= n_a;
            r_b     <= n_b;
            r_route <= n_route;
        end
    end

    assign o_valid = r_vld;
    assign o_a     = r_a;
    assign o_b     = r_b;
    assign o_route = r_route;

    // Only sphere mode swaps the axes
    a_swap_only_sphere: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_route.swap |-> (i_mode == EM_SPHERE))
        else $error("axis swap outside sphere mode");

endmodule

FILE: src/gtca_index.sv
// Index stages: picks final x and z, multiplies z by the grid width,
// then adds x into the output register. Depends on gtca_pkg.
`timescale 1ns / 1ps

module gtca_index #(
    parameter int RW = 12,
    parameter int SW = 13
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_ce,
    input  logic                            i_valid,
    input  gtca_pkg::t_route                i_route,
    input  logic [RW-1:0]                   i_a,
    input  logic [RW-1:0]                   i_b,
    input  logic [RW-1:0]                   i_rem_x,
    input  logic [RW-1:0]                   i_rem_z,
    input  logic [SW-1:0]                   i_nx,
    output logic                            o_valid,
    output logic [gtca_pkg::INDEX_W-1:0]    o_index,
    output logic                            o_in_grid
);
    import gtca_pkg::*;

    localparam int PW = RW + SW;

    logic               r_s2_vld;
    logic [PW-1:0]      r_s2_prod;
    logic [RW-1:0]      r_s2_x;
    logic               r_s2_ok;
    logic [RW-1:0]      n_x;
    logic [RW-1:0]      n_z;
    logic               r_vld;
    logic [INDEX_W-1:0] r_index;
    logic [INDEX_W-1:0] n_index;
    logic               r_ok;
    logic [PW-1:0]      w_sum;

    // Swapped items take the rewrapped values
    assign n_x = i_route.swap ? i_rem_x : i_a;
    assign n_z = i_route.swap ? i_rem_z : i_b;

    // Add the column and zero dropped items
    assign w_sum   = r_s2_prod + PW'(r_s2_x);
    assign n_index = r_s2_ok ? INDEX_W'(w_sum) : '0;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
            r_vld    <= 1'b0;
        end else if (i_ce) begin
            r_s2_vld <= i_valid;
            r_vld    <= r_s2_vld;
        end
    end

    // Multiply row by width, then register the index
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_s2_prod <= PW'(n_z) * PW'(i_nx);
            r_s2_x    <= n_x;
            r_s2_ok   <= i_route.ok;
            r_index   <= n_index;
            r_ok      <= r_s2_ok;
        end
    end

    assign o_valid   = r_vld;
    assign o_index   = r_index;
    assign o_in_grid = r_ok;

    // A dropped coordinate reports index zero
    a_dropped_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_in_grid |-> (o_index == '0))
        else $error("dropped coordinate with nonzero index");

endmodule

FILE: src/grid_topology_cell_address_unit.sv
// Grid topology cell address unit: top level with configuration registers,
// input stage and the pipeline built from gtca_divpipe, gtca_select and gtca_index.
// Depends on gtca_pkg.
//
// Use: each input transaction on the slave stream carries a signed (x, z)
// coordinate; the master stream returns one transaction per input with the
// linear cell index z*width+x under the configured edge topology, and an
// in-grid flag on tuser (index zero when the coordinate is dropped).
// The configuration channel writes edge mode, grid width and grid height;
// write it only while the pipeline is empty. Sides are clamped to 1..MAX.
// Pipeline stages: one input stage, fifteen divider stages for the first floor
// modulo, one select stage, one divider stage per remainder bit for the sphere
// rewrap, one multiply stage and one output stage. One transaction per cycle is
// taken while the receiver does not stall the output.
// Reset empties the pipeline and restores torus mode with a 64 by 64 grid.
// When the receiver stalls while a finished result waits in the output register,
// the whole pipeline holds and tready drops; otherwise tready stays high.
`timescale 1ns / 1ps

module grid_topology_cell_address_unit #(
    parameter int MAX_GRID_SIDE = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Slave stream, tdata: x_coord [15:0], z_coord [31:16]
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [2*gtca_pkg::COORD_W-1:0]     i_s_tdata,
    // Master stream, tdata: cell_index [23:0]; tuser: in_grid [0]
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [gtca_pkg::INDEX_W-1:0]       o_m_tdata,
    output logic                               o_m_tuser,
    // Configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [gtca_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gtca_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import gtca_pkg::*;

    localparam int NMAX = (MAX_GRID_SIDE > SIDE_REG_MAX) ? SIDE_REG_MAX : MAX_GRID_SIDE;
    localparam int SW   = $clog2(NMAX + 1);
    localparam int RW   = $clog2(NMAX);
    localparam int UW   = COORD_W - 1;
    localparam int SB2W = $bits(t_route) + 2 * RW;

    // Clamp a side register value into 1..NMAX
    function automatic logic [SW-1:0] f_side(input logic [CFG_DATA_W-1:0] v);
        if (v == '0) begin
            f_side = SW'(1);
        end else if (v > CFG_DATA_W'(NMAX)) begin
            f_side = SW'(NMAX);
        end else begin
            f_side = SW'(v);
        end
    endfunction

    t_edge_mode      r_mode;
    logic [SW-1:0]   r_nx;
    logic [SW-1:0]   r_nz;
    logic            w_ce;

    logic            r_s0_vld;
    logic [UW-1:0]   r_s0_ux;
    logic [UW-1:0]   r_s0_uz;
    t_axis_flags     r_s0_flags;
    t_axis_flags     n_s0_flags;
    logic [UW-1:0]   n_s0_ux;
    logic [UW-1:0]   n_s0_uz;

    logic            w_d1_vld;
    logic [RW-1:0]   w_d1_rem_x;
    logic [RW-1:0]   w_d1_rem_z;
    t_lane_odd       w_d1_odd;
    t_axis_flags     w_d1_flags;

    logic            w_s1_vld;
    logic [RW-1:0]   w_s1_a;
    logic [RW-1:0]   w_s1_b;
    t_route          w_s1_route;

    logic [SB2W-1:0] w_sb2_in;
    logic [SB2W-1:0] w_sb2_out;
    logic            w_d2_vld;
    logic [RW-1:0]   w_d2_rem_x;
    logic [RW-1:0]   w_d2_rem_z;
    t_route          w_d2_route;
    logic [RW-1:0]   w_d2_a;
    logic [RW-1:0]   w_d2_b;

    logic            w_out_vld;

    // Advance the whole pipeline unless the output register is stuck
    assign w_ce        = !w_out_vld || i_m_tready;
    assign o_s_tready  = w_ce;
    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= EM_TORUS;
            r_nx   <= f_side(CFG_DATA_W'(64));
            r_nz   <= f_side(CFG_DATA_W'(64));
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_EDGE_MODE:   r_mode <= t_edge_mode'(i_cfg_data[2:0]);
                CFG_GRID_WIDTH:  r_nx   <= f_side(i_cfg_data);
                CFG_GRID_HEIGHT: r_nz   <= f_side(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // Input stage: fold sign, check bounds for the dropping modes
    always_comb begin
        logic signed [COORD_W-1:0] v_x;
        logic signed [COORD_W-1:0] v_z;
        logic                      v_x_in;
        logic                      v_z_in;
        v_x    = i_s_tdata[COORD_W-1:0];
        v_z    = i_s_tdata[2*COORD_W-1:COORD_W];
        v_x_in = !v_x[COORD_W-1] && (v_x[UW-1:0] < UW'(r_nx));
        v_z_in = !v_z[COORD_W-1] && (v_z[UW-1:0] < UW'(r_nz));
        n_s0_flags.neg_x = v_x[COORD_W-1];
        n_s0_flags.neg_z = v_z[COORD_W-1];
        n_s0_ux = v_x[COORD_W-1] ? ~v_x[UW-1:0] : v_x[UW-1:0];
        n_s0_uz = v_z[COORD_W-1] ? ~v_z[UW-1:0] : v_z[UW-1:0];
        case (r_mode)
            EM_FINITE:   n_s0_flags.ok = v_x_in && v_z_in;
            EM_CYLINDER: n_s0_flags.ok = v_z_in;
            default:     n_s0_flags.ok = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (w_ce) begin
            r_s0_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_s0_ux    <= n_s0_ux;
            r_s0_uz    <= n_s0_uz;
            r_s0_flags <= n_s0_flags;
        end
    end

    // First floor modulo: x by width, z by height
    gtca_divpipe #(
        .DW   (UW),
        .RW   (RW),
        .SB_W ($bits(t_axis_flags))
    ) u_div_wrap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (r_s0_vld),
        .i_dvd_a (r_s0_ux),
        .i_dvd_b (r_s0_uz),
        .i_den_a ((RW+1)'(r_nx)),
        .i_den_b ((RW+1)'(r_nz)),
        .i_sb    (r_s0_flags),
        .o_valid (w_d1_vld),
        .o_rem_a (w_d1_rem_x),
        .o_rem_b (w_d1_rem_z),
        .o_odd   (w_d1_odd),
        .o_sb    (w_d1_flags)
    );

    gtca_select #(
        .RW (RW),
        .SW (SW)
    ) u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (w_d1_vld),
        .i_mode  (r_mode),
        .i_nx    (r_nx),
        .i_nz    (r_nz),
        .i_rem_x (w_d1_rem_x),
        .i_rem_z (w_d1_rem_z),
        .i_odd   (w_d1_odd),
        .i_flags (w_d1_flags),
        .o_valid (w_s1_vld),
        .o_a     (w_s1_a),
        .o_b     (w_s1_b),
        .o_route (w_s1_route)
    );

    // Second floor modulo for the sphere swap: z value into x, x value into z
    assign w_sb2_in = {w_s1_route, w_s1_a, w_s1_b};

    gtca_divpipe #(
        .DW   (RW),
        .RW   (RW),
        .SB_W (SB2W)
    ) u_div_swap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (w_s1_vld),
        .i_dvd_a (w_s1_b),
        .i_dvd_b (w_s1_a),
        .i_den_a ((RW+1)'(r_nx)),
        .i_den_b ((RW+1)'(r_nz)),
        .i_sb    (w_sb2_in),
        .o_valid (w_d2_vld),
        .o_rem_a (w_d2_rem_x),
        .o_rem_b (w_d2_rem_z),
        .o_odd   (),
        .o_sb    (w_sb2_out)
    );

    assign w_d2_route = w_sb2_out[SB2W-1:2*RW];
    assign w_d2_a     = w_sb2_out[2*RW-1:RW];
    assign w_d2_b     = w_sb2_out[RW-1:0];

    gtca_index #(
        .RW (RW),
        .SW (SW)
    ) u_index (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ce      (w_ce),
        .i_valid   (w_d2_vld),
        .i_route   (w_d2_route),
        .i_a       (w_d2_a),
        .i_b       (w_d2_b),
        .i_rem_x   (w_d2_rem_x),
        .i_rem_z   (w_d2_rem_z),
        .i_nx      (r_nx),
        .o_valid   (w_out_vld),
        .o_index   (o_m_tdata),
        .o_in_grid (o_m_tuser)
    );

    assign o_m_tvalid = w_out_vld;

    // Side registers always hold a usable divisor
    a_width_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nx != '0) && (r_nx <= SW'(NMAX)))
        else $error("grid width register out of range");

    a_height_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nz != '0) && (r_nz <= SW'(NMAX)))
        else $error("grid height register out of range");

    // A pending result is never dropped by a new input
    a_stall_keeps_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result lost");

endmodule
